FILE: rtl/tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tse_pkg
// shared constants, command codes and the edge update type for the
// topological sort engine
// ----------------------------------------------------------------------------
package tse_pkg;

  // store depth fixed by the 4-bit vertex fields
  localparam int STORE_DEPTH      = 16;
  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

  // command codes
  localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [1:0] CMD_SORT     = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // one update of the adjacency matrix, issued on an accepted item
  typedef struct packed {
    logic       add;
    logic       clear;
    logic [3:0] row;
    logic [3:0] col;
  } edge_op_t;

endpackage
`default_nettype wire

FILE: rtl/topological_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// topological_sort_engine
// Kahn topological sort over a directed graph kept as an adjacency bit matrix
// ----------------------------------------------------------------------------
// Add-edge, clear and unused command items are taken one per cycle; an edge
// with an endpoint at or above the vertex limit (MAX_VERTICES, at most 16) is
// dropped. A sort item holds cmd_stall high until its last result is taken.
// With n the effective vertex count (vertex_count clamped to 1..limit) a sort
// first counts in-degrees, one matrix row read per cycle through the single
// read port of the matrix memory, then walks the row of each dequeued vertex,
// one in-degree memory read-modify-write per successor, then emits results,
// waiting while the result side stalls. An acyclic graph gives n results in
// order with last on the final one; a cyclic graph gives one result with
// cyclic and last set and vertex_index zero. No clearing pass follows reset:
// the matrix rows carry valid flops, and clear drops them all at once. Write
// vertex_count only while the block is idle.
// ----------------------------------------------------------------------------
module topological_sort_engine #(
  parameter int MAX_VERTICES = tse_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [3:0] from_vertex,
  input  logic [3:0] to_vertex,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [3:0] vertex_index,
  output logic       last,
  output logic       cyclic,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  // vertex limit, storage depth and widths follow from it
  localparam int VLIM = (MAX_VERTICES < tse_pkg::STORE_DEPTH) ?
                        MAX_VERTICES : tse_pkg::STORE_DEPTH;
  localparam int AW   = $clog2(VLIM);
  localparam int CW   = AW + 1;
  localparam logic [4:0] VLIM5 = 5'(VLIM);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEG,
    ST_POP,
    ST_ROW,
    ST_WALK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  state_t state;

  logic [4:0]    vertex_count;
  logic [4:0]    n5;
  logic [CW-1:0] n_q;
  logic [CW-1:0] nm1;

  logic          cmd_accept;
  logic          in_limit;
  tse_pkg::edge_op_t edge_op;

  // matrix read port
  logic            mrd_en;
  logic [AW-1:0]   mrd_addr;
  logic [VLIM-1:0] row_bits;

  // in-degree memory
  logic [4:0]    deg_mem [VLIM];
  logic [4:0]    deg_rdata;
  logic          deg_re;
  logic [AW-1:0] deg_raddr;
  logic          deg_we;
  logic [AW-1:0] deg_waddr;
  logic [4:0]    deg_wdata;
  logic [4:0]    deg_sum;

  // ready queue memory; its first n entries are the final order
  logic [AW-1:0] q_mem [VLIM];
  logic [AW-1:0] q_rdata;
  logic          q_re;
  logic [AW-1:0] q_raddr;
  logic          enq;
  logic [AW-1:0] enq_idx;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;

  // in-degree count: issue side and returning row data
  logic          iss_active;
  logic [AW-1:0] iss_row;
  logic [AW-1:0] iss_col;
  logic          d_vld;
  logic [AW-1:0] d_col;
  logic          d_first;
  logic          d_last;
  logic          d_final;
  logic [4:0]    acc;

  // successor walk
  logic [AW-1:0] iss_j;
  logic          w_vld;
  logic [AW-1:0] w_j;
  logic          w_last;

  // emit index
  logic [AW-1:0] k;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid & ~cmd_stall;
  assign cfg_ready  = 1'b1;

  // effective vertex count
  always_comb begin
    if (vertex_count == 5'd0) begin
      n5 = 5'd1;
    end else if (vertex_count > VLIM5) begin
      n5 = VLIM5;
    end else begin
      n5 = vertex_count;
    end
  end

  assign nm1 = n_q - CW'(1);

  // edge updates; endpoints beyond the limit are dropped
  assign in_limit = ({1'b0, from_vertex} < VLIM5) && ({1'b0, to_vertex} < VLIM5);

  always_comb begin
    edge_op.add   = cmd_accept && (command == tse_pkg::CMD_ADD_EDGE) && in_limit;
    edge_op.clear = cmd_accept && (command == tse_pkg::CMD_CLEAR);
    edge_op.row   = from_vertex;
    edge_op.col   = to_vertex;
  end

  tse_edge_store #(
    .VLIM (VLIM)
  ) u_edge_store (
    .clk     (clk),
    .rst     (rst),
    .op      (edge_op),
    .rd_en   (mrd_en),
    .rd_addr (mrd_addr),
    .rd_row  (row_bits)
  );

  // memory port control for the sort phases
  always_comb begin
    mrd_en    = 1'b0;
    mrd_addr  = iss_row;
    deg_re    = 1'b0;
    deg_raddr = iss_j;
    deg_we    = 1'b0;
    deg_waddr = d_col;
    deg_wdata = 5'd0;
    q_re      = 1'b0;
    q_raddr   = k;
    enq       = 1'b0;
    enq_idx   = d_col;
    deg_sum   = (d_first ? 5'd0 : acc) + 5'(row_bits[d_col]);
    unique case (state)
      ST_DEG: begin
        // column sum of rows 0..n-1; written when the last row of the column returns
        mrd_en = iss_active;
        if (d_vld && d_last) begin
          deg_we    = 1'b1;
          deg_waddr = d_col;
          deg_wdata = deg_sum;
          enq       = (deg_sum == 5'd0);
          enq_idx   = d_col;
        end
      end
      ST_POP: begin
        q_re    = (head != tail);
        q_raddr = head[AW-1:0];
      end
      ST_ROW: begin
        // fetch the successor row of the dequeued vertex
        mrd_en   = 1'b1;
        mrd_addr = q_rdata;
      end
      ST_WALK: begin
        deg_re = iss_active;
        if (w_vld && row_bits[w_j] && (deg_rdata != 5'd0)) begin
          deg_we    = 1'b1;
          deg_waddr = w_j;
          deg_wdata = deg_rdata - 5'd1;
          enq       = (deg_rdata == 5'd1);
          enq_idx   = w_j;
        end
      end
      ST_EMIT_RD: begin
        q_re    = 1'b1;
        q_raddr = k;
      end
      ST_EMIT_HOLD: begin
        // prefetch the next order entry as the current result is taken
        q_re    = ~res_stall & ~last;
        q_raddr = k + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (deg_re) begin
      deg_rdata <= deg_mem[deg_raddr];
    end
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_re) begin
      q_rdata <= q_mem[q_raddr];
    end
    if (enq) begin
      q_mem[tail[AW-1:0]] <= enq_idx;
    end
  end

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= tse_pkg::VERTEX_COUNT_RESET;
      res_valid    <= 1'b0;
      iss_active   <= 1'b0;
      d_vld        <= 1'b0;
      w_vld        <= 1'b0;
      head         <= '0;
      tail         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (enq) begin
        tail <= tail + CW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_accept && (command == tse_pkg::CMD_SORT)) begin
            n_q        <= n5[CW-1:0];
            iss_row    <= '0;
            iss_col    <= '0;
            iss_active <= 1'b1;
            d_vld      <= 1'b0;
            head       <= '0;
            tail       <= '0;
            state      <= ST_DEG;
          end
        end
        ST_DEG: begin
          if (iss_active) begin
            d_vld   <= 1'b1;
            d_col   <= iss_col;
            d_first <= (iss_row == '0);
            d_last  <= ({1'b0, iss_row} == nm1);
            d_final <= ({1'b0, iss_row} == nm1) && ({1'b0, iss_col} == nm1);
            if ({1'b0, iss_row} == nm1) begin
              iss_row <= '0;
              if ({1'b0, iss_col} == nm1) begin
                iss_active <= 1'b0;
              end else begin
                iss_col <= iss_col + AW'(1);
              end
            end else begin
              iss_row <= iss_row + AW'(1);
            end
          end else begin
            d_vld <= 1'b0;
          end
          if (d_vld) begin
            acc <= deg_sum;
            if (d_final) begin
              state <= ST_POP;
            end
          end
        end
        ST_POP: begin
          if (head == tail) begin
            if (tail != n_q) begin
              // not every vertex came free: cycle among the rest
              res_valid    <= 1'b1;
              vertex_index <= 4'd0;
              last         <= 1'b1;
              cyclic       <= 1'b1;
              state        <= ST_EMIT_HOLD;
            end else begin
              k     <= '0;
              state <= ST_EMIT_RD;
            end
          end else begin
            head  <= head + CW'(1);
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          iss_j      <= '0;
          iss_active <= 1'b1;
          w_vld      <= 1'b0;
          state      <= ST_WALK;
        end
        ST_WALK: begin
          if (iss_active) begin
            w_vld  <= 1'b1;
            w_j    <= iss_j;
            w_last <= ({1'b0, iss_j} == nm1);
            if ({1'b0, iss_j} == nm1) begin
              iss_active <= 1'b0;
            end else begin
              iss_j <= iss_j + AW'(1);
            end
          end else begin
            w_vld <= 1'b0;
          end
          if (w_vld && w_last) begin
            state <= ST_POP;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          res_valid    <= 1'b1;
          vertex_index <= 4'(q_rdata);
          last         <= ({1'b0, k} == nm1);
          cyclic       <= 1'b0;
          state        <= ST_EMIT_HOLD;
        end
        ST_EMIT_HOLD: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= ST_EMIT_LD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only ever appears while the command side is held off
  a_res_during_sort: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cmd_stall)
    else $error("result valid while commands are accepted");

  // each vertex is queued at most once, so the queue never outgrows n
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (tail <= n_q))
    else $error("ready queue grew past the vertex count");

  // dequeue never overtakes enqueue
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (head <= tail))
    else $error("queue head passed the tail");

  // a cycle report is a single final result for vertex zero
  a_cyclic_form: assert property (@(posedge clk) disable iff (rst)
    (res_valid && cyclic) |-> (last && (vertex_index == 4'd0)))
    else $error("malformed cycle report");
`endif

endmodule
`default_nettype wire

FILE: rtl/tse_edge_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tse_edge_store
// adjacency matrix in a synchronous memory with registered read, one row per source
// vertex; row valid flops give instant clear, edge adds are read-modify-write
// with forwarding so one add can be taken every cycle
// ----------------------------------------------------------------------------
module tse_edge_store #(
  parameter  int VLIM = 16,
  localparam int AW   = $clog2(VLIM)
) (
  input  logic               clk,
  input  logic               rst,
  input  tse_pkg::edge_op_t  op,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VLIM-1:0]    rd_row
);

  logic [VLIM-1:0] mem [VLIM];
  logic [VLIM-1:0] row_vld;

  logic [VLIM-1:0] rdata;
  logic            rvld;
  logic            ren;
  logic [AW-1:0]   raddr;

  // write stage of an add or clear
  logic            s2_add;
  logic            s2_clear;
  logic [AW-1:0]   s2_row;
  logic [AW-1:0]   s2_col;

  // op that was in the write stage in the previous cycle
  logic            p_add;
  logic            p_clear;
  logic [AW-1:0]   p_row;
  logic [VLIM-1:0] p_data;

  logic [VLIM-1:0] base;
  logic [VLIM-1:0] wr_row;

  assign ren   = op.add | rd_en;
  assign raddr = op.add ? op.row[AW-1:0] : rd_addr;

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
      rvld  <= row_vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_add) begin
      mem[s2_row] <= wr_row;
    end
  end

  // the read of this add missed the write of the op just ahead of it
  always_comb begin
    if (p_clear) begin
      base = '0;
    end else if (p_add && (p_row == s2_row)) begin
      base = p_data;
    end else if (rvld) begin
      base = rdata;
    end else begin
      base = '0;
    end
  end

  assign wr_row = base | (VLIM'(1) << s2_col);
  assign rd_row = rvld ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      s2_add   <= 1'b0;
      s2_clear <= 1'b0;
      p_add    <= 1'b0;
      p_clear  <= 1'b0;
    end else begin
      s2_add   <= op.add;
      s2_clear <= op.clear;
      p_add    <= s2_add;
      p_clear  <= s2_clear;
      if (s2_clear) begin
        row_vld <= '0;
      end else if (s2_add) begin
        row_vld[s2_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_row <= op.row[AW-1:0];
    s2_col <= op.col[AW-1:0];
    p_row  <= s2_row;
    p_data <= wr_row;
  end

endmodule
`default_nettype wire
